FILE: rtl/core/vn_pkg.sv
// vn_pkg: widths, constants and pipeline payload types for the 3D vector
// normaliser. No dependencies; used by every file in rtl/core.
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;

  localparam int VN_W        = 32;          // component and length width
  localparam int VN_SQ_W     = 64;          // square and sum of squares
  localparam int VN_REM_W    = 34;          // square-root partial remainder
  localparam int VN_R_W      = 33;          // divider partial remainder
  localparam int VN_Q_W      = 31;          // quotient bits before clamping
  localparam int VN_SQRT_STEPS = 32;        // one result bit per cell
  localparam int VN_DIV_STEPS  = 31;        // one quotient bit per cell
  localparam logic [VN_W-1:0] VN_UNIT_ONE = 32'h4000_0000;

  // magnitudes and signs that ride alongside the square-root chain
  typedef struct packed {
    logic [2:0]              neg;
    logic [2:0][VN_W-1:0]    mag;
  } vn_side_t;

  // square-root cell payload
  typedef struct packed {
    logic [VN_SQ_W-1:0]  rad;
    logic [VN_REM_W-1:0] rem;
    logic [VN_W-1:0]     root;
    vn_side_t            side;
  } vn_sq_t;

  // divider cell payload, three lanes sharing one divisor
  typedef struct packed {
    logic [VN_W-1:0]             len;
    logic [2:0]                  neg;
    logic [2:0]                  ovf;
    logic [2:0][VN_R_W-1:0]      r;
    logic [2:0][VN_Q_W-1:0]      q;
  } vn_dv_t;

endpackage
`default_nettype wire

FILE: rtl/core/vn_in_if.sv
// vn_in_if: request channel carrying one Q16.16 vector.
// Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface vn_in_if import vn_pkg::*; ;
  logic            valid;
  logic            ready;
  logic [VN_W-1:0] x_in;
  logic [VN_W-1:0] y_in;
  logic [VN_W-1:0] z_in;
  modport source (output valid, x_in, y_in, z_in, input ready);
  modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/vn_out_if.sv
// vn_out_if: result channel carrying unit vector, length and zero flag.
// Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface vn_out_if import vn_pkg::*; ;
  logic            valid;
  logic            ready;
  logic [VN_W-1:0] x_unit;
  logic [VN_W-1:0] y_unit;
  logic [VN_W-1:0] z_unit;
  logic [VN_W-1:0] length;
  logic            zero_length;
  modport source (output valid, x_unit, y_unit, z_unit, length, zero_length, input ready);
  modport sink   (input valid, x_unit, y_unit, z_unit, length, zero_length, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/vn_sqrt_cell.sv
// vn_sqrt_cell: one digit-recurrence step of the integer square root,
// two radicand bits in, one root bit out. Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vn_sqrt_cell import vn_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic v_i,
  input  wire vn_sq_t d_i,
  output logic      v_o,
  output vn_sq_t    d_o
);

  logic [VN_REM_W+1:0] rem_sh;
  logic [VN_REM_W+1:0] trial;
  logic [VN_REM_W+1:0] diff;
  vn_sq_t              d_nxt;

  // bring in the next two radicand bits and try the candidate root bit
  always_comb begin
    rem_sh = {d_i.rem, d_i.rad[VN_SQ_W-1 -: 2]};
    trial  = {2'b00, d_i.root, 2'b01};
    diff   = rem_sh - trial;
    d_nxt      = d_i;
    d_nxt.rad  = {d_i.rad[VN_SQ_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      d_nxt.rem  = diff[VN_REM_W-1:0];
      d_nxt.root = {d_i.root[VN_W-2:0], 1'b1};
    end else begin
      d_nxt.rem  = rem_sh[VN_REM_W-1:0];
      d_nxt.root = {d_i.root[VN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/vn_div_cell.sv
// vn_div_cell: one restoring-division step for all three lanes, one
// quotient bit each. Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vn_div_cell import vn_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic v_i,
  input  wire vn_dv_t d_i,
  output logic      v_o,
  output vn_dv_t    d_o
);

  logic [2:0][VN_R_W-1:0] diff;
  logic [2:0]             ge;
  vn_dv_t                 d_nxt;

  // compare against the length, subtract where it fits, shift on
  always_comb begin
    d_nxt = d_i;
    for (int k = 0; k < 3; k++) begin
      diff[k] = d_i.r[k] - {1'b0, d_i.len};
      ge[k]   = d_i.r[k] >= {1'b0, d_i.len};
      d_nxt.q[k] = {d_i.q[k][VN_Q_W-2:0], ge[k]};
      if (ge[k]) begin
        d_nxt.r[k] = {diff[k][VN_W-1:0], 1'b0};
      end else begin
        d_nxt.r[k] = {d_i.r[k][VN_W-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/vector_normalize_3d.sv
// vector_normalize_3d: top level of the 3D vector normaliser.
// Depends on vn_pkg, vn_in_if, vn_out_if, vn_sqrt_cell, vn_div_cell.
//
// Usage:
//   in_ch  carries x_in, y_in, z_in (signed Q16.16) as a valid/ready request.
//   out_ch returns x_unit, y_unit, z_unit (signed Q1.30, clamped to +/-1.0),
//          length (unsigned Q16.16, floor of the magnitude) and zero_length.
//   A zero vector gives length 0, zero components and zero_length set.
// Pipeline: input register, squares, sum, 32 square-root cells
//   (one root bit each), 31 divider cells (one quotient bit each,
//   three lanes), output register; the whole cell chain advances together.
// Throughput: one vector per cycle while no result waits unread.
// Stall: while a result waits unread the chain freezes and in_ch.ready is
//   low; it rises as soon as the output register is taken or empty.
// Reset: rst_n (synchronous, active low) clears every valid bit; data in
//   flight is dropped.
`timescale 1ns / 1ps
`default_nettype none
module vector_normalize_3d import vn_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  vn_in_if.sink     in_ch,
  vn_out_if.source  out_ch
);

  logic en;
  logic out_v_r;

  // chain advance: output empty or being taken
  assign en           = !out_v_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = out_v_r;

  // input stage: magnitudes and signs
  logic                  s1_v_r;
  vn_side_t              s1_r, s1_nxt;
  always_comb begin
    s1_nxt.neg = {in_ch.z_in[VN_W-1], in_ch.y_in[VN_W-1], in_ch.x_in[VN_W-1]};
    s1_nxt.mag[0] = in_ch.x_in[VN_W-1] ? (~in_ch.x_in + 1'b1) : in_ch.x_in;
    s1_nxt.mag[1] = in_ch.y_in[VN_W-1] ? (~in_ch.y_in + 1'b1) : in_ch.y_in;
    s1_nxt.mag[2] = in_ch.z_in[VN_W-1] ? (~in_ch.z_in + 1'b1) : in_ch.z_in;
  end

  // squares stage
  logic                        s2_v_r;
  vn_side_t                    s2_r;
  logic [2:0][VN_SQ_W-1:0]     sq_r;

  // sum stage
  logic                 s3_v_r;
  vn_side_t             s3_r;
  logic [VN_SQ_W-1:0]   sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= {{VN_W{1'b0}}, s1_r.mag[k]} * {{VN_W{1'b0}}, s1_r.mag[k]};
      end
      s3_r  <= s2_r;
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  // square-root chain
  logic   [VN_SQRT_STEPS:0] sq_v;
  vn_sq_t [VN_SQRT_STEPS:0] sq_d;
  assign sq_v[0]      = s3_v_r;
  assign sq_d[0].rad  = sum_r;
  assign sq_d[0].rem  = '0;
  assign sq_d[0].root = '0;
  assign sq_d[0].side = s3_r;

  for (genvar i = 0; i < VN_SQRT_STEPS; i++) begin : g_sqrt
    vn_sqrt_cell u_cell (
      .clk (clk), .rst_n (rst_n), .en (en),
      .v_i (sq_v[i]), .d_i (sq_d[i]),
      .v_o (sq_v[i+1]), .d_o (sq_d[i+1])
    );
  end

  // divider set-up: quotient of 2^31 or more is flagged for clamping
  logic   [VN_DIV_STEPS:0] dv_v;
  vn_dv_t [VN_DIV_STEPS:0] dv_d;
  vn_dv_t                  dv_head;
  always_comb begin
    dv_head.len = sq_d[VN_SQRT_STEPS].root;
    dv_head.neg = sq_d[VN_SQRT_STEPS].side.neg;
    for (int k = 0; k < 3; k++) begin
      dv_head.ovf[k] = {1'b0, sq_d[VN_SQRT_STEPS].side.mag[k]} >=
                       {sq_d[VN_SQRT_STEPS].root, 1'b0};
      dv_head.r[k]   = {1'b0, sq_d[VN_SQRT_STEPS].side.mag[k]};
      dv_head.q[k]   = '0;
    end
  end
  assign dv_d[0] = dv_head;
  assign dv_v[0] = sq_v[VN_SQRT_STEPS];

  for (genvar i = 0; i < VN_DIV_STEPS; i++) begin : g_div
    vn_div_cell u_cell (
      .clk (clk), .rst_n (rst_n), .en (en),
      .v_i (dv_v[i]), .d_i (dv_d[i]),
      .v_o (dv_v[i+1]), .d_o (dv_d[i+1])
    );
  end

  // output stage: clamp, restore sign, zero-vector override
  logic [2:0][VN_W-1:0] unit_nxt, unit_r;
  logic [VN_W-1:0]      len_r;
  logic                 zero_nxt, zero_r;
  logic [VN_W-1:0]      qc;

  always_comb begin
    zero_nxt = dv_d[VN_DIV_STEPS].len == '0;
    for (int k = 0; k < 3; k++) begin
      qc = {1'b0, dv_d[VN_DIV_STEPS].q[k]};
      if (dv_d[VN_DIV_STEPS].ovf[k] || qc > VN_UNIT_ONE) begin
        qc = VN_UNIT_ONE;
      end
      if (zero_nxt) begin
        unit_nxt[k] = '0;
      end else if (dv_d[VN_DIV_STEPS].neg[k]) begin
        unit_nxt[k] = ~qc + 1'b1;
      end else begin
        unit_nxt[k] = qc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v[VN_DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_r <= unit_nxt;
      len_r  <= dv_d[VN_DIV_STEPS].len;
      zero_r <= zero_nxt;
    end
  end

  assign out_ch.x_unit      = unit_r[0];
  assign out_ch.y_unit      = unit_r[1];
  assign out_ch.z_unit      = unit_r[2];
  assign out_ch.length      = len_r;
  assign out_ch.zero_length = zero_r;

  // checks on the result register
  a_zero_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && zero_r |-> len_r == '0 && unit_r == '0)
    else $error("zero-length result with nonzero fields");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !zero_r |-> len_r != '0)
    else $error("nonzero result with zero length");

  a_x_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> $signed(unit_r[0]) <= $signed(VN_UNIT_ONE) &&
                $signed(unit_r[0]) >= -$signed(VN_UNIT_ONE))
    else $error("x_unit outside clamp range");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// tb_top: self-checking bench for vector_normalize_3d (length and unit vector).
// Depends on vn_pkg, vn_in_if, vn_out_if and the normaliser RTL.
`timescale 1ns / 1ps
module tb_top;
  import vn_pkg::*;

  typedef struct packed {
    logic [VN_W-1:0] x;
    logic [VN_W-1:0] y;
    logic [VN_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [VN_W-1:0] xu;
    logic [VN_W-1:0] yu;
    logic [VN_W-1:0] zu;
    logic [VN_W-1:0] len;
    logic            zf;
  } norm_t;

  localparam int LATENCY   = 67;
  localparam int WATCHDOG  = 20000;
  localparam int N_RANDOM  = 1750;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  vn_in_if  in_ch ();
  vn_out_if out_ch ();

  vector_normalize_3d dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  vec_t  pending_vecs[$];
  norm_t expected_norms[$];
  int    mismatches = 0;
  int    idle_cycles = 0;
  bit    stim_done = 0;
  bit    timed_out = 0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // integer square root, floor
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [VN_W-1:0] unit_of(input logic [VN_W-1:0] c, input logic [63:0] l);
    logic [63:0] m;
    logic [63:0] q;
    m = c[31] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
    q = (m << 30) / l;
    if (q > {32'd0, VN_UNIT_ONE}) q = {32'd0, VN_UNIT_ONE};
    return c[31] ? (32'd0 - q[31:0]) : q[31:0];
  endfunction

  function automatic norm_t normalise(input vec_t v);
    norm_t r;
    logic [63:0] mx, my, mz, l;
    mx = v.x[31] ? (64'h1_0000_0000 - {32'd0, v.x}) : {32'd0, v.x};
    my = v.y[31] ? (64'h1_0000_0000 - {32'd0, v.y}) : {32'd0, v.y};
    mz = v.z[31] ? (64'h1_0000_0000 - {32'd0, v.z}) : {32'd0, v.z};
    l = floor_sqrt(mx * mx + my * my + mz * mz);
    if (l == 0) begin
      r = '0;
      r.zf = 1'b1;
    end else begin
      r.xu = unit_of(v.x, l);
      r.yu = unit_of(v.y, l);
      r.zu = unit_of(v.z, l);
      r.len = l[31:0];
      r.zf = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 15) - 8;
      3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      4: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // stimulus: directed corners first, then random vectors
  initial begin
    vec_t v;
    logic [31:0] corners[6];
    corners = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd1,
                32'hffff_ffff, 32'h0001_0000};
    pending_vecs.push_back('{32'd0, 32'd0, 32'd0});
    pending_vecs.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    pending_vecs.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    pending_vecs.push_back('{32'h8000_0000, 32'd0, 32'd0});
    pending_vecs.push_back('{32'd0, 32'h7fff_ffff, 32'd0});
    pending_vecs.push_back('{32'd0, 32'd0, 32'hffff_ffff});
    pending_vecs.push_back('{32'd1, 32'd1, 32'd1});
    pending_vecs.push_back('{32'd1, 32'd1, 32'd0});
    pending_vecs.push_back('{32'd3, 32'd3, 32'd3});
    pending_vecs.push_back('{32'h0001_0000, 32'd0, 32'd0});
    pending_vecs.push_back('{32'hffff_0000, 32'h0001_0000, 32'h0001_0000});
    for (int i = 0; i < 12; i++) begin
      v.x = corners[$urandom_range(0, 5)];
      v.y = corners[$urandom_range(0, 5)];
      v.z = corners[$urandom_range(0, 5)];
      pending_vecs.push_back(v);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      v.x = rand_comp();
      v.y = rand_comp();
      v.z = rand_comp();
      pending_vecs.push_back(v);
    end
  end

  // driver
  int  send_gap = 0;
  logic [31:0] sent = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.x_in <= '0;
      in_ch.y_in <= '0;
      in_ch.z_in <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_norms.push_back(normalise({in_ch.x_in, in_ch.y_in, in_ch.z_in}));
        sent <= sent + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0 || pending_vecs.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
          if (pending_vecs.size() == 0) stim_done <= 1'b1;
        end else begin
          vec_t v;
          v = pending_vecs.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.x_in <= v.x;
          in_ch.y_in <= v.y;
          in_ch.z_in <= v.z;
          send_gap <= gap_len();
        end
      end
    end
  end

  // receiver stall pattern: one long hold-off once over 200 requests are sent, always ready while 601 to 899 are
  int  stall_cnt = 0;
  bit  long_done = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ch.ready <= (stall_cnt == 1);
    end else if (!long_done && sent > 200) begin
      long_done <= 1'b1;
      stall_cnt <= 300;
      out_ch.ready <= 1'b0;
    end else if (sent > 600 && sent < 900) begin
      out_ch.ready <= 1'b1;
    end else begin
      int g;
      g = gap_len();
      stall_cnt <= g;
      out_ch.ready <= (g == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      norm_t got, want;
      got = {out_ch.x_unit, out_ch.y_unit, out_ch.z_unit, out_ch.length, out_ch.zero_length};
      if (expected_norms.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_norms.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h z=%h len=%h zf=%b got x=%h y=%h z=%h len=%h zf=%b",
                     want.xu, want.yu, want.zu, want.len, want.zf,
                     got.xu, got.yu, got.zu, got.len, got.zf);
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles >= WATCHDOG) timed_out <= 1'b1;
  end

  // reset, then wait for the drain
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!timed_out && !(stim_done && !in_ch.valid && expected_norms.size() == 0))
      @(posedge clk);
    if (!timed_out) repeat (LATENCY + 10) @(posedge clk);
    if (timed_out) begin
      $display("CHECK FAILED");
    end else if (mismatches == 0 && expected_norms.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/vn_pkg.sv
rtl/core/vn_in_if.sv
rtl/core/vn_out_if.sv
rtl/core/vn_sqrt_cell.sv
rtl/core/vn_div_cell.sv
rtl/core/vector_normalize_3d.sv
bench/tb_top.sv
